@@ rtl/ehash_pkg.sv @@
// ----------------------------------------------------------------------------
// ehash_pkg: shared types and constants for the extendible hash table
// Transaction payloads, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ehash_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int SCAN_W = 8;

    // Fibonacci hash multiplier: golden ratio scaled to 32 bits
    localparam logic [KEY_W-1:0] GOLDEN = 32'h9E37_79B9;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_SEARCH  = 2'd2;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] found_value;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_DIR_RD,
        S_INFO_RD,
        S_INFO_GET,
        S_FIND,
        S_FIND_CMP,
        S_INS_CHK,
        S_TAKE,
        S_SP_WR,
        S_RE_RD,
        S_RE_MUL,
        S_RE_WR,
        S_RE_FIN_B,
        S_RE_FIN_N,
        S_INS_WR,
        S_RM_LAST,
        S_RM_MOVE,
        S_MG_RD1,
        S_MG_RD2,
        S_MG_RD3,
        S_MG_RD4,
        S_MG_CHK,
        S_MG_WR,
        S_DONE
    } t_state;

endpackage

@@ rtl/extendible_hash_table.sv @@
// ----------------------------------------------------------------------------
// extendible_hash_table: key/value store on extendible hashing
// Insert, remove and search of 32-bit keys; one result per operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one operation:
//   insert, remove or search. Output channel (o_out_valid / i_out_stall /
//   o_out_data) returns one status and found value per operation, in order.
//   One operation is worked at a time; o_in_stall is low only when idle, which
//   the sequencer enters as it registers the result. Each operation hashes the
//   key, reads the directory and then the bucket info, and compares the
//   bucket's stored keys one by one; an unknown operation skips the compare.
//   A bucket split tries free-bucket groups of eight (up to NUM_BUCKETS/8),
//   rewrites the directory slots of half the bucket's directory
//   range and re-enters each entry. A remove hit moves the last entry into
//   the hole, then merges an empty bucket with its buddy, rewriting the
//   merged directory range each time. All key hashing goes through
//   one shared 32x32 multiplier; the directory, the bucket info and the entry
//   store each have one read and one write port.
//   After reset the directory and bucket info are swept to zero, one word a
//   cycle over max(2^MAX_GLOBAL_DEPTH, NUM_BUCKETS) addresses, before the first
//   input is taken. A result waits in the output register while the
//   receiver stalls; the next operation is accepted meanwhile, and held at
//   its end until the output register frees.
// ----------------------------------------------------------------------------
module extendible_hash_table #(
    parameter int BUCKET_SIZE      = 4,
    parameter int MAX_GLOBAL_DEPTH = 8,
    parameter int NUM_BUCKETS      = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ehash_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ehash_pkg::t_out o_out_data
);

    localparam int M     = MAX_GLOBAL_DEPTH;
    localparam int DIR_N = 1 << M;
    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int FW    = $clog2(BUCKET_SIZE + 1);
    localparam int DW    = $clog2(M + 1);
    localparam int IW    = FW + DW;
    localparam int EN    = NUM_BUCKETS * BUCKET_SIZE;
    localparam int AW    = $clog2(EN);
    localparam int CLR_N = (DIR_N > NUM_BUCKETS) ? DIR_N : NUM_BUCKETS;
    localparam int CLW   = $clog2(CLR_N);
    localparam int UW    = $clog2(NUM_BUCKETS + 1);
    localparam int NG    = (NUM_BUCKETS + ehash_pkg::SCAN_W - 1) / ehash_pkg::SCAN_W;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int FV    = NG * ehash_pkg::SCAN_W;

    // memories
    logic [BW-1:0]     dir_mem  [DIR_N];
    logic [IW-1:0]     info_mem [NUM_BUCKETS];
    ehash_pkg::t_entry ent_mem  [EN];

    logic              dir_we, dir_re, info_we, info_re, ent_we, ent_re;
    logic [M-1:0]      dir_wa, dir_ra;
    logic [BW-1:0]     dir_wd;
    logic [BW-1:0]     info_wa, info_ra;
    logic [IW-1:0]     info_wd;
    logic [AW-1:0]     ent_wa, ent_ra;
    ehash_pkg::t_entry ent_wd;

    logic [BW-1:0]     r_dir_q;
    logic [IW-1:0]     r_info_q;
    ehash_pkg::t_entry r_ent_q;

    // sequencer and datapath registers
    ehash_pkg::t_state r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [31:0]       r_key, n_key, r_val, n_val, r_prod, n_prod;
    logic [M-1:0]      r_phys, n_phys, r_t, n_t, r_left, n_left;
    logic [BW-1:0]     r_b, n_b, r_nb, n_nb, r_keep, n_keep;
    logic [FW-1:0]     r_fill, n_fill, r_e, n_e, r_cb, n_cb, r_cn, n_cn, r_m, n_m;
    logic [DW-1:0]     r_ld, n_ld, r_gd, n_gd;
    logic [GW-1:0]     r_grp, n_grp;
    logic [FV-1:0]     r_free, n_free;
    logic [UW-1:0]     r_used, n_used;
    logic [CLW-1:0]    r_clr, n_clr;
    logic [1:0]        r_status, n_status;
    logic [31:0]       r_found, n_found;
    logic              r_out_vld, n_out_vld;
    ehash_pkg::t_out   r_out, n_out;

    // shared decisions
    logic [31:0]                  mul_a, mul_p;
    logic [FW-1:0]                info_fill;
    logic [DW-1:0]                info_ld;
    logic                         ent_hit, e_end, need_split, can_split, at_max, full;
    logic                         out_free, op_bad, merge_ok, to_nb;
    logic [M:0]                   pw;
    logic [M-1:0]                 half, lowmask, mg_mask, other, phys_e;
    logic [ehash_pkg::SCAN_W-1:0] grp_bits;
    logic                         grp_any;
    logic [2:0]                   grp_idx;

    function automatic logic [AW-1:0] ent_addr(input logic [BW-1:0] b,
                                               input logic [FW-1:0] e);
        ent_addr = AW'(b) * AW'(BUCKET_SIZE) + AW'(e);
    endfunction

    // shared multiplier: low word of key times golden constant
    assign mul_a = (r_state == ehash_pkg::S_RE_MUL) ? r_ent_q.key : r_key;
    assign mul_p = mul_a * ehash_pkg::GOLDEN;

    assign info_fill  = r_info_q[IW-1:DW];
    assign info_ld    = r_info_q[DW-1:0];
    assign ent_hit    = (r_ent_q.key == r_key);
    assign e_end      = (r_e == r_fill);
    assign need_split = (r_fill >= FW'(BUCKET_SIZE));
    assign can_split  = (r_ld < r_gd);
    assign at_max     = (r_gd >= DW'(M));
    assign full       = (r_used == UW'(NUM_BUCKETS));
    assign out_free   = !r_out_vld || !i_out_stall;
    assign op_bad     = (r_op != ehash_pkg::OP_INSERT) && (r_op != ehash_pkg::OP_REMOVE)
                        && (r_op != ehash_pkg::OP_SEARCH);
    assign merge_ok   = (r_b != r_nb) && (r_ld == info_ld)
                        && ((r_fill == '0) || (info_fill == '0));

    // directory range of the current bucket level
    assign pw      = (M + 1)'(1) << (DW'(M) - r_ld);
    assign half    = M'(pw >> 1);
    assign lowmask = M'(pw - 1'b1);
    assign mg_mask = M'((pw << 1) - 1'b1);
    assign other   = (r_phys & ~lowmask) | (((r_phys & half) != '0) ? '0 : half);
    assign phys_e  = r_prod[31 -: M];
    assign to_nb   = ((phys_e ^ r_phys) & half) != '0;

    // free-bucket scan, one group of eight per cycle
    assign grp_bits = r_free[r_grp * ehash_pkg::SCAN_W +: ehash_pkg::SCAN_W];
    assign grp_any  = |grp_bits;
    always_comb begin
        grp_idx = '0;
        for (int j = ehash_pkg::SCAN_W - 1; j >= 0; j--) begin
            if (grp_bits[j]) begin
                grp_idx = 3'(j);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ehash_pkg::S_CLEAR:    if (r_clr == CLW'(CLR_N - 1)) n_state = ehash_pkg::S_IDLE;
            ehash_pkg::S_IDLE:     if (i_in_valid) n_state = ehash_pkg::S_HASH;
            ehash_pkg::S_HASH:     n_state = ehash_pkg::S_DIR_RD;
            ehash_pkg::S_DIR_RD:   n_state = ehash_pkg::S_INFO_RD;
            ehash_pkg::S_INFO_RD:  n_state = ehash_pkg::S_INFO_GET;
            ehash_pkg::S_INFO_GET: n_state = op_bad ? ehash_pkg::S_DONE : ehash_pkg::S_FIND;
            ehash_pkg::S_FIND: begin
                if (!e_end) begin
                    n_state = ehash_pkg::S_FIND_CMP;
                end else if (r_op == ehash_pkg::OP_INSERT) begin
                    n_state = ehash_pkg::S_INS_CHK;
                end else begin
                    n_state = ehash_pkg::S_DONE;
                end
            end
            ehash_pkg::S_FIND_CMP: begin
                if (!ent_hit) begin
                    n_state = ehash_pkg::S_FIND;
                end else if (r_op == ehash_pkg::OP_REMOVE) begin
                    n_state = ehash_pkg::S_RM_LAST;
                end else begin
                    n_state = ehash_pkg::S_DONE;
                end
            end
            ehash_pkg::S_INS_CHK: begin
                if (!need_split) begin
                    n_state = ehash_pkg::S_INS_WR;
                end else if (full || (!can_split && at_max)) begin
                    n_state = ehash_pkg::S_DONE;
                end else begin
                    n_state = ehash_pkg::S_TAKE;
                end
            end
            ehash_pkg::S_TAKE:     if (grp_any) n_state = ehash_pkg::S_SP_WR;
            ehash_pkg::S_SP_WR:    if (r_left == '0) n_state = ehash_pkg::S_RE_RD;
            ehash_pkg::S_RE_RD:    n_state = e_end ? ehash_pkg::S_RE_FIN_B : ehash_pkg::S_RE_MUL;
            ehash_pkg::S_RE_MUL:   n_state = ehash_pkg::S_RE_WR;
            ehash_pkg::S_RE_WR:    n_state = ehash_pkg::S_RE_RD;
            ehash_pkg::S_RE_FIN_B: n_state = ehash_pkg::S_RE_FIN_N;
            ehash_pkg::S_RE_FIN_N: n_state = ehash_pkg::S_INS_CHK;
            ehash_pkg::S_INS_WR:   n_state = ehash_pkg::S_DONE;
            ehash_pkg::S_RM_LAST:  n_state = ehash_pkg::S_RM_MOVE;
            ehash_pkg::S_RM_MOVE:  n_state = ehash_pkg::S_MG_RD1;
            ehash_pkg::S_MG_RD1:   n_state = (r_ld == '0) ? ehash_pkg::S_DONE : ehash_pkg::S_MG_RD2;
            ehash_pkg::S_MG_RD2:   n_state = ehash_pkg::S_MG_RD3;
            ehash_pkg::S_MG_RD3:   n_state = ehash_pkg::S_MG_RD4;
            ehash_pkg::S_MG_RD4:   n_state = ehash_pkg::S_MG_CHK;
            ehash_pkg::S_MG_CHK:   n_state = merge_ok ? ehash_pkg::S_MG_WR : ehash_pkg::S_DONE;
            ehash_pkg::S_MG_WR:    if (r_left == '0) n_state = ehash_pkg::S_MG_RD1;
            ehash_pkg::S_DONE:     if (out_free) n_state = ehash_pkg::S_IDLE;
            default:               n_state = ehash_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_op = r_op;   n_key = r_key;   n_val = r_val;   n_prod = r_prod;
        n_phys = r_phys; n_t = r_t; n_left = r_left;
        n_b = r_b; n_nb = r_nb; n_keep = r_keep;
        n_fill = r_fill; n_e = r_e; n_cb = r_cb; n_cn = r_cn; n_m = r_m;
        n_ld = r_ld; n_gd = r_gd; n_grp = r_grp; n_free = r_free; n_used = r_used;
        n_clr = r_clr; n_status = r_status; n_found = r_found;
        n_out = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        dir_we = 1'b0;  dir_wa = r_t;  dir_wd = r_nb;  dir_re = 1'b0;  dir_ra = r_phys;
        info_we = 1'b0; info_wa = r_b; info_wd = {r_fill, r_ld};
        info_re = 1'b0; info_ra = r_b;
        ent_we = 1'b0;  ent_wa = ent_addr(r_b, r_e); ent_wd = r_ent_q;
        ent_re = 1'b0;  ent_ra = ent_addr(r_b, r_e);
        case (r_state)
            // sweep directory and bucket info to zero
            ehash_pkg::S_CLEAR: begin
                n_clr   = r_clr + 1'b1;
                dir_we  = ({1'b0, r_clr} < (CLW + 1)'(DIR_N));
                dir_wa  = r_clr[M-1:0];
                dir_wd  = '0;
                info_we = ({1'b0, r_clr} < (CLW + 1)'(NUM_BUCKETS));
                info_wa = r_clr[BW-1:0];
                info_wd = '0;
            end
            ehash_pkg::S_IDLE: begin
                n_op     = i_in_data.operation;
                n_key    = i_in_data.key;
                n_val    = i_in_data.value;
                n_status = ehash_pkg::ST_MISS;
                n_found  = '0;
            end
            ehash_pkg::S_HASH: n_prod = mul_p;
            ehash_pkg::S_DIR_RD: begin
                n_phys = r_prod[31 -: M];
                dir_re = 1'b1;
                dir_ra = r_prod[31 -: M];
            end
            ehash_pkg::S_INFO_RD: begin
                n_b     = r_dir_q;
                info_re = 1'b1;
                info_ra = r_dir_q;
            end
            ehash_pkg::S_INFO_GET: begin
                n_fill = info_fill;
                n_ld   = info_ld;
                n_e    = '0;
            end
            ehash_pkg::S_FIND: ent_re = !e_end;
            // compare one stored key
            ehash_pkg::S_FIND_CMP: begin
                if (ent_hit) begin
                    n_m = r_e;
                    if (r_op == ehash_pkg::OP_SEARCH) begin
                        n_status = ehash_pkg::ST_OK;
                        n_found  = r_ent_q.value;
                    end
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            // decide between store, split, doubling and full
            ehash_pkg::S_INS_CHK: begin
                if (need_split) begin
                    if (full || (!can_split && at_max)) begin
                        n_status = ehash_pkg::ST_FULL;
                    end else if (!can_split) begin
                        n_gd = r_gd + 1'b1;
                    end
                end
            end
            // take the first free bucket, set up its directory range
            ehash_pkg::S_TAKE: begin
                if (grp_any) begin
                    n_nb           = BW'(int'(r_grp) * ehash_pkg::SCAN_W + int'(grp_idx));
                    n_free         = r_free;
                    n_free[n_nb]   = 1'b0;
                    n_used         = r_used + 1'b1;
                    n_t            = other;
                    n_left         = half - 1'b1;
                    n_e            = '0;
                    n_cb           = '0;
                    n_cn           = '0;
                end else begin
                    n_grp = (r_grp == GW'(NG - 1)) ? '0 : r_grp + 1'b1;
                end
            end
            ehash_pkg::S_SP_WR: begin
                dir_we = 1'b1;
                dir_wa = r_t;
                dir_wd = r_nb;
                n_t    = r_t + 1'b1;
                n_left = r_left - 1'b1;
            end
            ehash_pkg::S_RE_RD:  ent_re = !e_end;
            ehash_pkg::S_RE_MUL: n_prod = mul_p;
            // drop the entry into its half of the split
            ehash_pkg::S_RE_WR: begin
                ent_we = 1'b1;
                ent_wd = r_ent_q;
                n_e    = r_e + 1'b1;
                if (to_nb) begin
                    ent_wa = ent_addr(r_nb, r_cn);
                    n_cn   = r_cn + 1'b1;
                end else begin
                    ent_wa = ent_addr(r_b, r_cb);
                    n_cb   = r_cb + 1'b1;
                end
            end
            ehash_pkg::S_RE_FIN_B: begin
                info_we = 1'b1;
                info_wa = r_b;
                info_wd = {r_cb, r_ld + 1'b1};
                n_fill  = r_cb;
                n_ld    = r_ld + 1'b1;
            end
            ehash_pkg::S_RE_FIN_N: begin
                info_we = 1'b1;
                info_wa = r_nb;
                info_wd = {r_cn, r_ld};
            end
            ehash_pkg::S_INS_WR: begin
                ent_we   = 1'b1;
                ent_wa   = ent_addr(r_b, r_fill);
                ent_wd   = '{key: r_key, value: r_val};
                info_we  = 1'b1;
                info_wa  = r_b;
                info_wd  = {r_fill + 1'b1, r_ld};
                n_status = ehash_pkg::ST_OK;
            end
            ehash_pkg::S_RM_LAST: begin
                ent_re = 1'b1;
                ent_ra = ent_addr(r_b, r_fill - 1'b1);
            end
            // move the last entry into the hole
            ehash_pkg::S_RM_MOVE: begin
                ent_we   = 1'b1;
                ent_wa   = ent_addr(r_b, r_m);
                ent_wd   = r_ent_q;
                info_we  = 1'b1;
                info_wa  = r_b;
                info_wd  = {r_fill - 1'b1, r_ld};
                n_fill   = r_fill - 1'b1;
                n_status = ehash_pkg::ST_OK;
            end
            ehash_pkg::S_MG_RD1: begin
                dir_re = (r_ld != '0);
                dir_ra = r_phys;
            end
            ehash_pkg::S_MG_RD2: begin
                n_b    = r_dir_q;
                dir_re = 1'b1;
                dir_ra = r_phys ^ M'(pw);
            end
            ehash_pkg::S_MG_RD3: begin
                n_nb    = r_dir_q;
                info_re = 1'b1;
                info_ra = r_b;
            end
            ehash_pkg::S_MG_RD4: begin
                n_fill  = info_fill;
                info_re = 1'b1;
                info_ra = r_nb;
            end
            // fold the empty buddy into the other one
            ehash_pkg::S_MG_CHK: begin
                if (merge_ok) begin
                    info_we = 1'b1;
                    if (r_fill == '0) begin
                        n_keep            = r_nb;
                        n_free[r_b]       = 1'b1;
                        info_wa           = r_nb;
                        info_wd           = {info_fill, r_ld - 1'b1};
                    end else begin
                        n_keep            = r_b;
                        n_free[r_nb]      = 1'b1;
                        info_wa           = r_b;
                        info_wd           = {r_fill, r_ld - 1'b1};
                    end
                    n_used = r_used - 1'b1;
                    n_t    = r_phys & ~mg_mask;
                    n_left = mg_mask;
                end
            end
            ehash_pkg::S_MG_WR: begin
                dir_we = 1'b1;
                dir_wa = r_t;
                dir_wd = r_keep;
                n_t    = r_t + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == '0) begin
                    n_ld = r_ld - 1'b1;
                end
            end
            // hand the result to the output register
            ehash_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.status      = r_status;
                    n_out.found_value = r_found;
                end
            end
            default: begin
            end
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_wa] <= dir_wd;
        end
        if (dir_re) begin
            r_dir_q <= dir_mem[dir_ra];
        end
        if (info_we) begin
            info_mem[info_wa] <= info_wd;
        end
        if (info_re) begin
            r_info_q <= info_mem[info_ra];
        end
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            r_ent_q <= ent_mem[ent_ra];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ehash_pkg::S_CLEAR;
            r_clr     <= '0;
            r_gd      <= DW'(1);
            r_used    <= UW'(1);
            r_grp     <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < FV; i++) begin
                r_free[i] <= (i > 0) && (i < NUM_BUCKETS);
            end
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_gd      <= n_gd;
            r_used    <= n_used;
            r_grp     <= n_grp;
            r_out_vld <= n_out_vld;
            r_free    <= n_free;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_prod   <= n_prod;
        r_phys   <= n_phys;
        r_t      <= n_t;
        r_left   <= n_left;
        r_b      <= n_b;
        r_nb     <= n_nb;
        r_keep   <= n_keep;
        r_fill   <= n_fill;
        r_e      <= n_e;
        r_cb     <= n_cb;
        r_cn     <= n_cn;
        r_m      <= n_m;
        r_ld     <= n_ld;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != ehash_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // free map and bucket count agree
    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_free) == NUM_BUCKETS - int'(r_used))
        else $error("free map and used count disagree");

    // global depth stays within its bounds
    a_gd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gd >= DW'(1)) && (r_gd <= DW'(M)))
        else $error("global depth out of range");

    // re-entered entries are all accounted for
    a_reenter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ehash_pkg::S_RE_RD) |-> (FW'(r_cb + r_cn) == r_e))
        else $error("split lost or duplicated an entry");

    // a result appears only from the finishing state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ehash_pkg::S_DONE))
        else $error("result raised outside of finish");

endmodule
